[hw/rtl/text_console_terminal_engine_assert.svh]
// Assertion macros for the text console terminal engine checker.
// Taken in by the checker file only; no other dependencies.
`ifndef TEXT_CONSOLE_TERMINAL_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_TERMINAL_ENGINE_ASSERT_SVH

// Same-cycle implication, masked while reset is low
`define TCE_ASSERT_IMP(NAME, CLK, RSTN, ANTE, CONS) \
  NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("tce checker: implication failed");

// Next-cycle implication, masked while reset is low
`define TCE_ASSERT_NXT(NAME, CLK, RSTN, ANTE, CONS) \
  NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("tce checker: next-cycle implication failed");

`endif

[hw/rtl/tce_pkg.sv]
// Shared constants and widths for the text console terminal engine.
// No dependencies; used by the top level and the checker.
`default_nettype none

package tce_pkg;

  // field widths
  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 7;
  localparam int POS_W     = 12;
  localparam int CELL_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_HIDDEN = 1'd1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;

  // attribute after reset
  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h0F;

endpackage

`default_nettype wire

[hw/rtl/tce_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/text_console_terminal_engine.sv]
// Text console terminal engine: screen store in one RAM plus cursor registers.
// Depends on tce_pkg and tce_ram.
//
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   Each item gives one result beat on out_* marked by out_strobe for one
//   cycle; the receiver always takes it. Config writes (cfg_index 0 text
//   color, 1 cursor hidden) are taken whenever cfg_valid is high.
// Sequences (the screen RAM has one write port, so whole-screen work goes
// one cell per cycle):
//   Put byte, valid set cursor: write (put only), read cursor cell,
//   write back recolor; no write back when the cursor is hidden.
//   Read cell: read at accept, result from S_READ. Out-of-range set or read:
//   result in the cycle after accept.
//   Clear screen: every cell blanked, then the cursor recolor steps.
//   Newline on the bottom row (scroll): rows copied up, bottom row blanked, then recolor.
// Reset: the RAM is swept to blanks with attribute 0x0F, one cell per
// cycle; busy stays high meanwhile.
// One item at a time; busy is low again in the cycle the result shows.
`default_nettype none

module text_console_terminal_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tce_pkg::OP_W-1:0]      in_operation,
  input  wire logic [tce_pkg::CHAR_W-1:0]    in_char_byte,
  input  wire logic [tce_pkg::ROW_W-1:0]     in_row,
  input  wire logic [tce_pkg::COL_W-1:0]     in_col,
  // result channel
  output logic                               out_strobe,
  output logic                               out_status,
  output logic [tce_pkg::POS_W-1:0]          out_cursor_position,
  output logic [tce_pkg::CHAR_W-1:0]         out_cell_char,
  // configuration channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tce_pkg::CFG_DAT_W-1:0] cfg_data
);

  import tce_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELLS - COLUMNS);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_CLEAR  = 8'b0000_0100,
    S_SCROLL = 8'b0000_1000,
    S_FILL   = 8'b0001_0000,
    S_POST   = 8'b0010_0000,
    S_RCLR   = 8'b0100_0000,
    S_READ   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CHAR_W-1:0] color_r;
  logic              hidden_r;

  logic              out_strobe_r;
  logic              out_status_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [CHAR_W-1:0] out_char_r;

  // RAM port signals
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;

  // result staging
  logic              fin;
  logic              fin_status;
  logic [CHAR_W-1:0] fin_char;

  logic [POS_W-1:0]  cur_lin;
  logic [POS_W-1:0]  in_lin;
  logic [ADDR_W-1:0] cur_addr;
  logic              in_range;
  logic              at_bottom;
  logic              at_last_col;
  logic              printable;
  logic              accept;
  logic [CELL_W-1:0] blank_cell;

  tce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // cursor and input addresses
  assign cur_lin     = POS_W'(row_r) * POS_W'(COLUMNS) + POS_W'(col_r);
  assign in_lin      = POS_W'(in_row) * POS_W'(COLUMNS) + POS_W'(in_col);
  assign cur_addr    = cur_lin[ADDR_W-1:0];
  assign in_range    = (in_row < ROW_W'(ROWS)) && (in_col < COL_W'(COLUMNS));
  assign at_bottom   = row_r >= ROW_W'(ROWS - 1);
  assign at_last_col = col_r >= COL_W'(COLUMNS - 1);
  assign printable   = (in_char_byte >= CH_BLANK) && (in_char_byte <= CH_PRINT_HI);
  assign accept      = start && (state_r == S_IDLE);
  assign blank_cell  = {color_r, CH_BLANK};

  // sequencer: RAM access and next state
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    we         = 1'b0;
    waddr      = cur_addr;
    wdata      = blank_cell;
    raddr      = cur_addr;
    fin        = 1'b0;
    fin_status = 1'b0;
    fin_char   = '0;

    unique case (state_r)
      S_INIT: begin
        we    = 1'b1;
        waddr = cnt_r;
        wdata = {RESET_ATTR, CH_BLANK};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            OP_PUT: begin
              state_nxt = S_POST;
              priority if (in_char_byte == CH_CR) begin
                col_nxt = '0;
              end else if (in_char_byte == CH_LF) begin
                col_nxt = '0;
                if (at_bottom) begin
                  cnt_nxt   = '0;
                  state_nxt = S_SCROLL;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end else if (in_char_byte == CH_BS) begin
                if (col_r != '0) begin
                  col_nxt = col_r - 1'b1;
                  we      = 1'b1;
                  waddr   = cur_addr - 1'b1;
                end
              end else begin
                we    = printable;
                wdata = {color_r, in_char_byte};
                if (at_last_col) begin
                  col_nxt = '0;
                  if (at_bottom) begin
                    cnt_nxt   = '0;
                    state_nxt = S_SCROLL;
                  end else begin
                    row_nxt = row_r + 1'b1;
                  end
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end
            end

            OP_SET: begin
              if (in_range) begin
                row_nxt   = in_row;
                col_nxt   = in_col;
                state_nxt = S_POST;
              end else begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end
            end

            OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_CLEAR;
            end

            OP_READ: begin
              if (in_range) begin
                raddr     = in_lin[ADDR_W-1:0];
                state_nxt = S_READ;
              end else begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end
            end

            default: ;
          endcase
        end
      end

      S_CLEAR: begin
        we      = 1'b1;
        waddr   = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) begin
          state_nxt = S_POST;
        end
      end

      // copy each cell up one row: read source now, write the previous one
      S_SCROLL: begin
        if (cnt_r != SCROLL_END) begin
          raddr   = ADDR_W'({1'b0, cnt_r} + (ADDR_W + 1)'(COLUMNS));
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = S_FILL;
        end
        we    = cnt_r != '0;
        waddr = cnt_r - 1'b1;
        wdata = rdata;
      end

      // blank the bottom row
      S_FILL: begin
        we      = 1'b1;
        waddr   = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) begin
          state_nxt = S_POST;
        end
      end

      // cursor recolor: read the cursor cell unless hidden
      S_POST: begin
        if (hidden_r) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RCLR;
        end
      end

      S_RCLR: begin
        we        = 1'b1;
        wdata     = {color_r, rdata[CHAR_W-1:0]};
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end

      S_READ: begin
        fin       = 1'b1;
        fin_char  = rdata[CHAR_W-1:0];
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_INIT;
        cnt_nxt   = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cnt_r        <= '0;
      row_r        <= '0;
      col_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      out_strobe_r <= fin;
    end
  end

  // result payload; cursor regs are final when fin is high
  always_ff @(posedge clk) begin
    if (fin) begin
      out_status_r <= fin_status;
      out_char_r   <= fin_char;
      out_pos_r    <= hidden_r ? cur_lin + POS_W'(CELLS) : cur_lin;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r  <= RESET_ATTR;
      hidden_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEXT_COLOR:    color_r  <= cfg_data;
        REG_CURSOR_HIDDEN: hidden_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy                = state_r != S_IDLE;
  assign cfg_ready           = 1'b1;
  assign out_strobe          = out_strobe_r;
  assign out_status          = out_status_r;
  assign out_cursor_position = out_pos_r;
  assign out_cell_char       = out_char_r;

endmodule

`default_nettype wire

[hw/rtl/tce_checker.sv]
// Port-level checker for the text console terminal engine, bound to the top.
// Depends on tce_pkg and text_console_terminal_engine_assert.svh.
`include "text_console_terminal_engine_assert.svh"
`default_nettype none

module tce_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_strobe,
  input wire logic                       out_status,
  input wire logic [tce_pkg::CHAR_W-1:0] out_cell_char
);

  import tce_pkg::*;

  // an accepted beat keeps the block busy or answers in the next cycle
  `TCE_ASSERT_NXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_strobe)

  // a result beat only follows work in flight or an accept
  `TCE_ASSERT_IMP(a_strobe_has_cause, clk, rst_n, out_strobe, $past(busy || start))

  // the block is free again when a result shows
  `TCE_ASSERT_IMP(a_idle_on_result, clk, rst_n, out_strobe, !busy)

  // an error result carries no character
  `TCE_ASSERT_IMP(a_error_no_char, clk, rst_n, out_strobe && out_status,
                  out_cell_char == CHAR_W'(0))

endmodule

bind text_console_terminal_engine tce_checker u_tce_checker (.*);

`default_nettype wire
